// ===== rtl/qs_pkg.sv =====
// Shared types, constants and helper functions for the quaternion blend block.
`timescale 1ns / 1ps
package qs_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 40;
  localparam int QDEPTH       = 4;

  localparam logic [14:0]        THR_RESET = 15'd32752;
  localparam logic signed [33:0] INV_GAIN  = 34'sd652032874;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_NONE      = 1'b1
  } qs_reg_t;

  // request as classified by the front end; qb is already sign corrected
  typedef struct packed {
    logic [3:0][15:0] qa;
    logic [3:0][16:0] qb;
    logic [15:0]      frac;
    logic [29:0]      cosv;
    logic             lin;
  } qs_req_t;

  // fields that ride along the whole back end
  typedef struct packed {
    qs_req_t          req;
    logic [3:0][31:0] comp;
    logic [31:0]      root;
  } qs_carry_t;

  typedef struct packed {
    logic [3:0][15:0] q;
    logic             lin;
  } qs_res_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
    logic signed [33:0] val;
    case (idx)
      5'd0:    val = 34'sd843314857;
      5'd1:    val = 34'sd497837829;
      5'd2:    val = 34'sd263043837;
      5'd3:    val = 34'sd133525159;
      5'd4:    val = 34'sd67021687;
      5'd5:    val = 34'sd33543516;
      5'd6:    val = 34'sd16775851;
      5'd7:    val = 34'sd8388437;
      5'd8:    val = 34'sd4194283;
      5'd9:    val = 34'sd2097149;
      default: val = 34'sd1 <<< (5'd30 - idx);
    endcase
    return val;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7fff;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/qs_front.sv =====
// Front end: takes requests, forms the inner product and picks the path.
`timescale 1ns / 1ps
module qs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [3:0][15:0]    a,
  input  logic [3:0][15:0]    b,
  input  logic [15:0]         blend,
  input  logic [14:0]         thr,
  input  logic                q_full,
  output logic                q_push,
  output qs_pkg::qs_req_t     q_data
);
  import qs_pkg::*;

  logic                fv;
  logic [3:0][15:0]    fa;
  logic [3:0][15:0]    fb;
  logic [15:0]         ffrac;
  logic signed [31:0]  prod [4];
  logic                take;
  logic signed [33:0]  dot;
  logic [33:0]         cosa;
  logic                neg;

  assign take   = push && !full;
  assign full   = fv && q_full;
  assign q_push = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fa    <= a;
      fb    <= b;
      ffrac <= (blend > 16'd32768) ? 16'd32768 : blend;
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(a[i]) * $signed(b[i]);
      end
    end
  end

  always_comb begin
    dot  = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
    neg  = dot[33];
    cosa = neg ? 34'(-dot) : 34'(dot);
    q_data.qa   = fa;
    q_data.frac = ffrac;
    q_data.cosv = cosa[29:0];
    q_data.lin  = cosa > {4'b0, thr, 15'b0};
    // shortest arc: flip b when the cosine is negative
    for (int i = 0; i < 4; i++) begin
      q_data.qb[i] = neg ? 17'(-$signed({fb[i][15], fb[i]})) : {fb[i][15], fb[i]};
    end
  end

endmodule

// ===== rtl/qs_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module qs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qs_pkg::qs_req_t  wdata,
  output logic             full,
  input  logic             pop,
  output qs_pkg::qs_req_t  rdata,
  output logic             empty
);
  import qs_pkg::*;

  qs_req_t     mem [QDEPTH];
  logic [1:0]  wp;
  logic [1:0]  rp;
  logic [2:0]  cnt;

  assign full  = (cnt == 3'(QDEPTH));
  assign empty = (cnt == 3'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (push) begin
        wp <= wp + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      if (push && !pop) begin
        cnt <= cnt + 3'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ===== rtl/qs_back.sv =====
// Back end: square root, CORDIC angle and sines, division, blend and result queue.
`timescale 1ns / 1ps
module qs_back (
  input  logic             clk,
  input  logic             rst,
  input  qs_pkg::qs_req_t  q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output qs_pkg::qs_res_t  res,
  output logic             empty,
  input  logic             pop
);
  import qs_pkg::*;

  localparam int ST_P3  = 2;
  localparam int ST_VEC = ST_P3 + 1 + SQRT_STEPS;
  localparam int ST_M1  = ST_VEC + CORDIC_STEPS;
  localparam int ST_ROT = ST_M1 + 2;
  localparam int ST_D0  = ST_ROT + CORDIC_STEPS;
  localparam int ST_DIV = ST_D0 + 1;
  localparam int ST_E1  = ST_DIV + DIV_STEPS;
  localparam int N_STG  = ST_E1 + 1;

  logic               adv;
  logic [N_STG-1:0]   vld;
  qs_carry_t          carry    [N_STG];
  qs_carry_t          carry_nx [N_STG];

  // ---- entry stages
  logic [3:0][31:0]   comp_in;
  logic [59:0]        cos2;
  logic [3:0][60:0]   sq;
  logic [60:0]        rad_s;

  // ---- square root
  logic [63:0]        sq_val  [SQRT_STEPS];
  logic [63:0]        sq_root [SQRT_STEPS+1];

  // ---- vectoring
  logic signed [33:0] vx [CORDIC_STEPS];
  logic signed [33:0] vy [CORDIC_STEPS];
  logic signed [33:0] va [CORDIC_STEPS+1];

  logic signed [33:0] m_ang;
  logic signed [50:0] m_prod;
  logic signed [33:0] za;
  logic signed [33:0] zb;

  // ---- rotation, lane 0 for a and lane 1 for b
  logic signed [33:0] rx [2][CORDIC_STEPS];
  logic signed [33:0] ry [2][CORDIC_STEPS+1];
  logic signed [33:0] rz [2][CORDIC_STEPS];

  // ---- division
  logic [3:0][63:0]   dnum;
  logic [3:0]         dneg [DIV_STEPS+1];
  logic [31:0]        drem [4][DIV_STEPS];
  logic [39:0]        dlo  [4][DIV_STEPS];
  logic [39:0]        dq   [4][DIV_STEPS+1];

  // ---- blend
  logic [3:0][15:0]   lin_o;
  logic signed [57:0] pa [4];
  logic signed [57:0] pb [4];
  qs_res_t            res_in;

  // ---- result queue
  qs_res_t            oq [2];
  logic               oq_wp;
  logic               oq_rp;
  logic [1:0]         oq_cnt;
  logic               oq_push;
  logic               oq_pop;

  assign adv     = (oq_cnt != 2'd2);
  assign q_pop   = adv && !q_empty;
  assign oq_push = adv && vld[N_STG-1];
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt == 2'd0);
  assign res     = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_STG-2:0], q_pop};
    end
  end

  // linear blend components, exact
  always_comb begin
    logic signed [17:0] wl_a;
    logic signed [17:0] wl_b;
    logic signed [35:0] t;
    wl_b = $signed({2'b0, q_data.frac});
    wl_a = 18'sd32768 - wl_b;
    for (int i = 0; i < 4; i++) begin
      t = $signed(q_data.qa[i]) * wl_a + $signed(q_data.qb[i]) * wl_b;
      comp_in[i] = t[31:0];
    end
  end

  always_comb begin
    carry_nx[0].req  = q_data;
    carry_nx[0].comp = comp_in;
    carry_nx[0].root = '0;
    for (int i = 1; i < N_STG; i++) begin
      carry_nx[i] = carry[i-1];
    end
    carry_nx[ST_VEC].root = sq_root[SQRT_STEPS][31:0];
  end

  for (genvar s = 0; s < N_STG; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        carry[s] <= carry_nx[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] sqs;
    if (adv) begin
      cos2 <= q_data.cosv * q_data.cosv;
      for (int i = 0; i < 4; i++) begin
        sqs   = $signed(carry[0].comp[i]) * $signed(carry[0].comp[i]);
        sq[i] <= sqs[60:0];
      end
      rad_s <= 61'd1152921504606846976 - {1'b0, cos2};
      sq_val[0]  <= carry[1].req.lin ?
                    64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]) : 64'(rad_s);
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = sq_root[k] + BITV;
    assign ge    = (sq_val[k] >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root[k+1] <= ge ? (sq_root[k] >> 1) + BITV : sq_root[k] >> 1;
      end
    end
    if (k < SQRT_STEPS - 1) begin : g_val
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_val[k+1] <= ge ? sq_val[k] - trial : sq_val[k];
        end
      end
    end
  end

  // vectoring: angle of (cos, sin)
  assign vx[0] = $signed({4'b0, carry[ST_VEC-1].req.cosv});
  assign vy[0] = $signed({2'b0, sq_root[SQRT_STEPS][31:0]});
  assign va[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    localparam logic signed [33:0] ATV = atan_entry(5'(k));
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic               up;
    assign dx = vy[k] >>> k;
    assign dy = vx[k] >>> k;
    assign up = !vy[k][33];
    always_ff @(posedge clk) begin
      if (adv) begin
        va[k+1] <= up ? va[k] + ATV : va[k] - ATV;
      end
    end
    if (k < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (adv) begin
          vx[k+1] <= up ? vx[k] + dx : vx[k] - dx;
          vy[k+1] <= up ? vy[k] - dy : vy[k] + dy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] ab;
    if (adv) begin
      m_ang  <= va[CORDIC_STEPS];
      m_prod <= va[CORDIC_STEPS] * $signed({1'b0, carry[ST_M1-1].req.frac});
      ab     = 34'(m_prod >>> 15);
      zb     <= ab;
      za     <= m_ang - ab;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_lane
    assign rx[j][0] = INV_GAIN;
    assign ry[j][0] = '0;
    assign rz[j][0] = (j == 0) ? za : zb;
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      localparam logic signed [33:0] ATV = atan_entry(5'(k));
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic               pos;
      assign dx  = ry[j][k] >>> k;
      assign dy  = rx[j][k] >>> k;
      assign pos = !rz[j][k][33];
      always_ff @(posedge clk) begin
        if (adv) begin
          ry[j][k+1] <= pos ? ry[j][k] + dy : ry[j][k] - dy;
        end
      end
      if (k < CORDIC_STEPS - 1) begin : g_xz
        always_ff @(posedge clk) begin
          if (adv) begin
            rx[j][k+1] <= pos ? rx[j][k] - dx : rx[j][k] + dx;
            rz[j][k+1] <= pos ? rz[j][k] - ATV : rz[j][k] + ATV;
          end
        end
      end
    end
  end

  // numerators for the rounded divisions; the divisor is always the root
  always_ff @(posedge clk) begin
    logic signed [31:0] c;
    logic [31:0]        cm;
    logic signed [33:0] sn;
    logic [33:0]        sm;
    logic [63:0]        half;
    if (adv) begin
      half = 64'(carry[ST_D0-1].root >> 1);
      for (int i = 0; i < 4; i++) begin
        if (carry[ST_D0-1].req.lin) begin
          c  = $signed(carry[ST_D0-1].comp[i]);
          cm = c[31] ? 32'(-c) : 32'(c);
          dneg[0][i] <= c[31];
          dnum[i]    <= 64'({cm, 15'b0}) + half;
        end else if (i < 2) begin
          sn = ry[i][CORDIC_STEPS];
          sm = sn[33] ? 34'(-sn) : 34'(sn);
          dneg[0][i] <= sn[33];
          dnum[i]    <= (64'(sm) << 30) + half;
        end else begin
          dneg[0][i] <= 1'b0;
          dnum[i]    <= '0;
        end
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_dlane
    assign drem[j][0] = {8'b0, dnum[j][63:40]};
    assign dlo[j][0]  = dnum[j][39:0];
    assign dq[j][0]   = '0;
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [32:0] r;
      logic [32:0] den;
      logic        ge;
      assign den = {1'b0, carry[ST_D0+k].root};
      assign r   = {drem[j][k], dlo[j][k][39]};
      assign ge  = (r >= den);
      always_ff @(posedge clk) begin
        if (adv) begin
          dq[j][k+1] <= {dq[j][k][38:0], ge};
        end
      end
      if (k < DIV_STEPS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            drem[j][k+1] <= ge ? 32'(r - den) : r[31:0];
            dlo[j][k+1]  <= {dlo[j][k][38:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dneg
    always_ff @(posedge clk) begin
      if (adv) begin
        dneg[k+1] <= dneg[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [40:0] wa;
    logic signed [40:0] wb;
    logic signed [63:0] qv;
    logic               zero;
    if (adv) begin
      zero = (carry[ST_E1-1].root == 32'd0);
      wa = dneg[DIV_STEPS][0] ? -$signed({1'b0, dq[0][DIV_STEPS]})
                              : $signed({1'b0, dq[0][DIV_STEPS]});
      wb = dneg[DIV_STEPS][1] ? -$signed({1'b0, dq[1][DIV_STEPS]})
                              : $signed({1'b0, dq[1][DIV_STEPS]});
      for (int i = 0; i < 4; i++) begin
        qv = dneg[DIV_STEPS][i] ? -$signed(64'(dq[i][DIV_STEPS]))
                                : $signed(64'(dq[i][DIV_STEPS]));
        lin_o[i] <= zero ? 16'd0 : sat16(qv);
        pa[i]    <= $signed(carry[ST_E1-1].req.qa[i]) * wa;
        pb[i]    <= $signed(carry[ST_E1-1].req.qb[i]) * wb;
      end
    end
  end

  // spherical blend: round the Q.30 sum half away from zero
  always_comb begin
    logic signed [58:0] s;
    logic [58:0]        mag;
    logic [58:0]        rnd;
    logic signed [63:0] sv;
    res_in.lin = carry[ST_E1].req.lin;
    for (int i = 0; i < 4; i++) begin
      s   = 59'(pa[i]) + 59'(pb[i]);
      mag = s[58] ? 59'(-s) : 59'(s);
      rnd = (mag + 59'd536870912) >> 30;
      sv  = s[58] ? -$signed(64'(rnd)) : $signed(64'(rnd));
      res_in.q[i] = carry[ST_E1].req.lin ? lin_o[i] : sat16(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wp <= !oq_wp;
      end
      if (oq_pop) begin
        oq_rp <= !oq_rp;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt <= oq_cnt + 2'd1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt <= oq_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wp] <= res_in;
    end
  end

`ifndef SYNTH
  a_oq_bound: assert property (@(posedge clk) disable iff (rst) oq_cnt != 2'd3)
    else $error("result queue count out of range");
  a_take_enters: assert property (@(posedge clk) disable iff (rst) q_pop |=> vld[0])
    else $error("request taken from queue did not enter the pipeline");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !oq_pop) |=> oq_cnt == $past(oq_cnt) + 2'd1)
    else $error("result queue lost a request");
`endif

endmodule

// ===== rtl/quaternion_slerp.sv =====
// Quaternion spherical blend with normalized linear fallback, fixed point.
// Throughput: one request per cycle while the result queue has room,
// set by the fully pipelined back end (32 square root steps,
// 2 x 30 CORDIC steps, 40 division steps).
// Reset (synchronous): queues and pipeline empty, threshold back to 32752.
`timescale 1ns / 1ps
module quaternion_slerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic signed [15:0] b_w,
  input  logic [15:0]        blend,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               linear_path
);
  import qs_pkg::*;

  logic [14:0] thr;
  qs_reg_t     reg_sel;
  qs_req_t     f_data;
  qs_req_t     q_data;
  qs_res_t     res;
  logic        f_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  assign pready  = 1'b1;
  assign reg_sel = qs_reg_t'(paddr[2]);
  assign prdata  = (reg_sel == REG_THRESHOLD) ? {17'b0, thr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_THRESHOLD) begin
      thr <= pwdata[14:0];
    end
  end

  qs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .a      ({a_w, a_z, a_y, a_x}),
    .b      ({b_w, b_z, b_y, b_x}),
    .blend  (blend),
    .thr    (thr),
    .q_full (q_full),
    .q_push (f_push),
    .q_data (f_data)
  );

  qs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  qs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign out_x       = res.q[0];
  assign out_y       = res.q[1];
  assign out_z       = res.q[2];
  assign out_w       = res.q[3];
  assign linear_path = res.lin;

endmodule

// ===== test/quaternion_slerp_tb.sv =====
// Self-checking testbench for the fixed-point quaternion blend block.
`timescale 1ns / 1ps
module quaternion_slerp_tb;
  import qs_pkg::*;

  localparam int  LATENCY     = 142;
  localparam longint MAX_CYCLES = 400000;
  localparam longint ONE_Q15  = 32768;
  localparam longint INV_GAIN_Q30 = 652032874;

  typedef struct {
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic [15:0]        blend;
  } quat_req_t;

  typedef struct {
    logic signed [15:0] q [4];
    logic               lin;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
  logic signed [15:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
  logic [15:0] blend = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  logic linear_path;

  quat_res_t blend_expect_q[$];
  logic [14:0] thr_model = THR_RESET;
  int  err_count = 0;
  longint cycle_count = 0;
  bit  tx_idle = 1'b1, rx_idle = 1'b1, hold_rx = 1'b0;
  int  rx_gap = 0;

  always #5 clk = ~clk;

  quaternion_slerp uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .blend(blend),
    .empty(empty), .pop(pop),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .linear_path(linear_path)
  );

  // ---------------- blend predictor ----------------
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    longint unsigned mag, quo;
    mag = (num >= 0) ? num : -num;
    quo = (mag + longint'(den) / 2) / den;
    return (num >= 0) ? longint'(quo) : -longint'(quo);
  endfunction

  function automatic longint arctan_step(int i);
    longint tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    return (i < 10) ? tab[i] : (longint'(1) << (30 - i));
  endfunction

  function automatic longint vector_angle(longint cx, longint cy);
    longint ang, dx, dy;
    ang = 0;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += arctan_step(i);
      end else begin
        cx -= dx; cy += dy; ang -= arctan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic longint rotate_sine(longint ang);
    longint cx, cy, dx, dy;
    cx = INV_GAIN_Q30;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= arctan_step(i);
      end else begin
        cx += dx; cy -= dy; ang += arctan_step(i);
      end
    end
    return cy;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic quat_res_t slerp_predict(quat_req_t r, logic [14:0] thr);
    longint qa [4], qb [4], comp [4];
    longint dotp, frac, len, sn, ang, ang_b, wa, wb;
    longint unsigned sumsq;
    quat_res_t res;
    dotp = 0;
    for (int i = 0; i < 4; i++) begin
      qa[i] = r.a[i];
      qb[i] = r.b[i];
      dotp += qa[i] * qb[i];
    end
    frac = r.blend;
    if (frac > ONE_Q15) frac = ONE_Q15;
    if (dotp < 0) begin
      dotp = -dotp;
      for (int i = 0; i < 4; i++) qb[i] = -qb[i];
    end
    if (dotp > (longint'(thr) << 15)) begin
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
        comp[i] = qa[i] * (ONE_Q15 - frac) + qb[i] * frac;
        sumsq += comp[i] * comp[i];
      end
      len = root_floor(sumsq);
      for (int i = 0; i < 4; i++)
        res.q[i] = (len > 0) ? clamp16(div_half_away(comp[i] * ONE_Q15, len)) : 16'sd0;
      res.lin = 1'b1;
    end else begin
      sn = root_floor((64'd1 << 60) - dotp * dotp);
      ang = vector_angle(dotp, sn);
      ang_b = (ang * frac) >>> 15;
      wa = div_half_away(rotate_sine(ang - ang_b) * (longint'(1) << 30), sn);
      wb = div_half_away(rotate_sine(ang_b) * (longint'(1) << 30), sn);
      for (int i = 0; i < 4; i++)
        res.q[i] = clamp16(div_half_away(qa[i] * wa + qb[i] * wb, longint'(1) << 30));
      res.lin = 1'b0;
    end
    return res;
  endfunction

  // ---------------- driving ----------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_request(quat_req_t r);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    {a_x, a_y, a_z, a_w} = {r.a[0], r.a[1], r.a[2], r.a[3]};
    {b_x, b_y, b_z, b_w} = {r.b[0], r.b[1], r.b[2], r.b[3]};
    blend = r.blend;
    push = 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    blend_expect_q.push_back(slerp_predict(r, thr_model));
    @(negedge clk);
  endtask

  // waits for every result, then the pipeline latency, before a register write
  task automatic drain();
    push = 1'b0;
    while (blend_expect_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(qs_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(int'(idx) * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_THRESHOLD) thr_model = val[14:0];
  endtask

  function automatic quat_req_t make_req(int av, int bv, int t);
    quat_req_t r;
    for (int i = 0; i < 4; i++) begin
      r.a[i] = 16'(av);
      r.b[i] = 16'(bv);
    end
    r.blend = 16'(t);
    return r;
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] v, int span);
    int s;
    s = int'(v) + $urandom_range(0, 2 * span) - span;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  function automatic quat_req_t random_req();
    quat_req_t r;
    int kind, span;
    kind = $urandom_range(0, 3);
    span = 1 << $urandom_range(0, 12);
    for (int i = 0; i < 4; i++) begin
      r.a[i] = 16'($urandom);
      r.b[i] = 16'($urandom);
    end
    case (kind)
      1: for (int i = 0; i < 4; i++) r.b[i] = nudge(r.a[i], span);
      2: begin
        // roughly unit quaternions: one dominant component
        for (int i = 0; i < 4; i++) begin
          r.a[i] = nudge(16'sd0, 4096);
          r.b[i] = nudge(16'sd0, 4096);
        end
        r.a[$urandom_range(0, 3)] = ($urandom_range(0, 1)) ? 16'sd32767 : -16'sd32768;
        r.b[$urandom_range(0, 3)] = ($urandom_range(0, 1)) ? 16'sd30000 : -16'sd30000;
      end
      3: for (int i = 0; i < 4; i++) r.b[i] = nudge(-r.a[i], span);
      default: ;
    endcase
    r.blend = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(32769, 65535))
                                          : 16'($urandom_range(0, 32768));
    return r;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    quat_req_t r;
    int vals [6] = '{-32768, 32767, 0, 1, -1, 16384};
    int ts [4] = '{0, 16384, 32768, 65535};
    foreach (vals[i]) send_request(make_req(vals[i], vals[(i + 1) % 6], ts[i % 4]));
    send_request(make_req(32767, 32767, 16384));    // cosine far beyond one
    send_request(make_req(-32768, 32767, 32768));   // negative cosine, path flip
    send_request(make_req(0, 0, 16384));            // zero cosine, zero inputs
    send_request(make_req(23170, -23170, 40000));   // blend above one
    r = make_req(0, 0, 8192);
    r.a[3] = 16'sd32767; r.b[0] = 16'sd32767;       // orthogonal pair
    send_request(r);
    r.b[3] = 16'sd32000; r.b[0] = 16'sd7000;        // moderate angle
    send_request(r);
    r.b[3] = 16'sd32767; r.b[0] = 16'sd100;         // cosine just over threshold
    send_request(r);
    for (int i = 0; i < 4; i++) begin
      r = make_req(0, 0, $urandom_range(0, 32768));
      r.a[i] = 16'sh8000; r.b[i] = 16'sh8000; r.b[(i + 1) % 4] = 16'sd200;
      send_request(r);
    end
    drain();
  endtask

  task automatic test_thresholds();
    logic [31:0] settings [6] = '{32'd0, 32'd32767, 32'hffff_ffff, 32'd16384,
                                  32'd30000, 32'd32752};
    foreach (settings[s]) begin
      write_reg(REG_THRESHOLD, (s == 5) ? 32'($urandom_range(0, 32767)) : settings[s]);
      if (s == 2) write_reg(REG_NONE, 32'd5);     // write to unmapped index
      repeat (100) send_request(random_req());
      drain();
    end
    write_reg(REG_THRESHOLD, 32'(THR_RESET));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (500) @(negedge clk);
        hold_rx = 1'b0;
      end
      repeat (200) send_request(random_req());
    join
    drain();
  endtask

  task automatic test_streaming();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (120) send_request(random_req());
    drain();
  endtask

  // ---------------- result side ----------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        pop = 1'b0;
      end else if (rx_gap > 0) begin
        pop = 1'b0;
        rx_gap--;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        pop = 1'b0;
        rx_gap = $urandom_range(0, 5);
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    quat_res_t want;
    if (!rst && pop && !empty) begin
      if (blend_expect_q.size() == 0) begin
        $display("[%0t] result with no request outstanding", $time);
        err_count++;
      end else begin
        want = blend_expect_q.pop_front();
        if (out_x !== want.q[0]) report_mismatch("out_x", out_x, want.q[0]);
        if (out_y !== want.q[1]) report_mismatch("out_y", out_y, want.q[1]);
        if (out_z !== want.q[2]) report_mismatch("out_z", out_z, want.q[2]);
        if (out_w !== want.q[3]) report_mismatch("out_w", out_w, want.q[3]);
        if (linear_path !== want.lin) report_mismatch("linear_path", linear_path, want.lin);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("quaternion_slerp regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_thresholds();
    test_backpressure();
    test_streaming();
    if (err_count == 0) begin
      $display("quaternion_slerp regression: pass");
    end else begin
      $display("quaternion_slerp regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qs_pkg.sv
rtl/qs_front.sv
rtl/qs_queue.sv
rtl/qs_back.sv
rtl/quaternion_slerp.sv
test/quaternion_slerp_tb.sv
